// ----- design/cfr_pkg.sv -----
// Shared types and constants for the CRC-checked frame receiver.
// No dependencies; imported by cfr_frame_core and the top level.
package cfr_pkg;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_OK   = 2'd1,
    KIND_FAIL = 2'd2
  } kind_t;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned ADDR_W = 9;

  // Configuration register map (index = paddr[2])
  localparam int unsigned PADDR_W  = 3;
  localparam logic        REG_POLY = 1'b0;
  localparam logic        REG_OFFS = 1'b1;

  // Register reset values
  localparam logic [BYTE_W-1:0] POLY_RESET = 8'd137;
  localparam logic [BYTE_W-1:0] OFFS_RESET = 8'd0;

  // One result item
  typedef struct packed {
    kind_t             kind;
    logic [ADDR_W-1:0] store_address;
    logic [BYTE_W-1:0] store_data;
  } result_t;

endpackage

// ----- design/cfr_frame_core.sv -----
// Frame parser: length / data / check byte sequencing and CRC-8 folding.
// Depends on cfr_pkg.
module cfr_frame_core import cfr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,        // process one item this cycle
  input  logic [BYTE_W-1:0] rx_byte,
  input  logic [BYTE_W-1:0] crc_poly,
  input  logic [BYTE_W-1:0] start_offset,
  output logic              res_valid,
  output result_t           res
);

  logic              in_frame_r, in_frame_nxt;
  logic [BYTE_W-1:0] length_r, length_nxt;
  logic [BYTE_W-1:0] pos_r, pos_nxt;
  logic [BYTE_W-1:0] chk_r, chk_nxt;
  logic [BYTE_W-1:0] chk_fold;

  // Reflected CRC-8 byte update: xor in, then eight shift rounds
  function automatic logic [BYTE_W-1:0] fold_byte(
    input logic [BYTE_W-1:0] acc_in,
    input logic [BYTE_W-1:0] b,
    input logic [BYTE_W-1:0] poly
  );
    logic [BYTE_W-1:0] acc;
    acc = acc_in ^ b;
    for (int r = 0; r < BYTE_W; r++) begin
      if (acc[0]) acc = acc ^ poly;
      acc = acc >> 1;
    end
    return acc;
  endfunction

  assign chk_fold = fold_byte(chk_r, rx_byte, crc_poly);

  // Next state and result
  always_comb begin
    in_frame_nxt = in_frame_r;
    length_nxt   = length_r;
    pos_nxt      = pos_r;
    chk_nxt      = chk_r;
    res_valid    = 1'b0;
    res.kind          = KIND_DATA;
    res.store_address = '0;
    res.store_data    = '0;
    if (!in_frame_r) begin
      // length byte: open frame, no result
      in_frame_nxt = 1'b1;
      length_nxt   = rx_byte;
      pos_nxt      = '0;
      chk_nxt      = '0;
    end else begin
      chk_nxt   = chk_fold;
      res_valid = 1'b1;
      if (pos_r < length_r) begin
        res.kind          = KIND_DATA;
        res.store_address = {1'b0, start_offset} + {1'b0, pos_r};
        res.store_data    = rx_byte;
        pos_nxt           = pos_r + 1'b1;
      end else begin
        // check byte: report and wait for next length byte
        res.kind     = (chk_fold == '0) ? KIND_OK : KIND_FAIL;
        in_frame_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      length_r   <= '0;
      pos_r      <= '0;
      chk_r      <= '0;
    end else if (step) begin
      in_frame_r <= in_frame_nxt;
      length_r   <= length_nxt;
      pos_r      <= pos_nxt;
      chk_r      <= chk_nxt;
    end
  end

endmodule

// ----- design/crc_checked_frame_receiver_top.sv -----
// CRC-checked frame receiver. Each byte is registered on entry and then
// parsed into a registered result, so one item per cycle is sustained while
// out_stall does not hold the result register: an accepted item goes into the
// input register, then into the result register, which drives out_valid.
// Frames are a length byte, that many data bytes (each emitted with its
// buffer address), and a check byte whose CRC-8 fold must leave zero (OK)
// or else FAIL is reported. The length byte gives no result. Registers:
// 0x0 polynomial (reset 0x89), 0x4 start offset (reset 0); write them only
// while the block is idle.
// Depends on cfr_pkg and cfr_frame_core.
module crc_checked_frame_receiver_top import cfr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [BYTE_W-1:0]  in_rx_byte,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_kind,
  output logic [ADDR_W-1:0]  out_store_address,
  output logic [BYTE_W-1:0]  out_store_data
);

  logic [BYTE_W-1:0] poly_r, offs_r;
  logic              cfg_wr;
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              out_ready;
  logic              step;
  logic              res_valid;
  result_t           res;
  logic              out_valid_r;
  result_t           out_r;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r <= POLY_RESET;
      offs_r <= OFFS_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_POLY: poly_r <= pwdata[BYTE_W-1:0];
        REG_OFFS: offs_r <= pwdata[BYTE_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_POLY: prdata = {24'd0, poly_r};
      REG_OFFS: prdata = {24'd0, offs_r};
      default:  prdata = '0;
    endcase
  end

  // Handshake: stage 1 drains whenever the result register can take a value
  assign out_ready = !out_valid_r || !out_stall;
  assign step      = s1_valid_r && out_ready;
  assign in_stall  = s1_valid_r && !out_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  cfr_frame_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .rx_byte      (s1_byte_r),
    .crc_poly     (poly_r),
    .start_offset (offs_r),
    .res_valid    (res_valid),
    .res          (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_r.kind;
  assign out_store_address = out_r.store_address;
  assign out_store_data    = out_r.store_data;

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking bench for crc_checked_frame_receiver_top: directed frames, then random
// frames under several polynomial/offset settings, scored against an in-bench predictor.
// Depends on cfr_pkg and the receiver RTL.
module tb_top;
  import cfr_pkg::*;

  // One row of the directed table; want is used only when typed is set
  typedef struct packed {
    logic [7:0] rx;
    bit         good_check;
    bit         typed;
    result_t    want;
  } dir_row_t;

  localparam int DIR_ROWS_N = 16;
  localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
    '{8'h00, 1'b0, 1'b0, '0},                          // zero length
    '{8'h00, 1'b0, 1'b1, '{KIND_OK, 9'd0, 8'h00}},     // check of empty frame
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},                          // bad check on empty frame
    '{8'h03, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b1, '{KIND_DATA, 9'd0, 8'h00}},
    '{8'hFF, 1'b0, 1'b1, '{KIND_DATA, 9'd1, 8'hFF}},
    '{8'hA5, 1'b0, 1'b1, '{KIND_DATA, 9'd2, 8'hA5}},
    '{8'h00, 1'b1, 1'b1, '{KIND_OK, 9'd0, 8'h00}},     // matching check byte
    '{8'h02, 1'b0, 1'b0, '0},
    '{8'h5A, 1'b0, 1'b1, '{KIND_DATA, 9'd0, 8'h5A}},
    '{8'h81, 1'b0, 1'b1, '{KIND_DATA, 9'd1, 8'h81}},
    '{8'h00, 1'b0, 1'b0, '0},                          // arbitrary check byte
    '{8'h01, 1'b0, 1'b0, '0},
    '{8'h7E, 1'b0, 1'b1, '{KIND_DATA, 9'd0, 8'h7E}},
    '{8'h00, 1'b1, 1'b1, '{KIND_OK, 9'd0, 8'h00}}
  };

  // Register settings for the random phases; the last phase is fully random
  localparam int PHASES = 5;
  localparam logic [7:0] PHASE_POLY [PHASES-1] = '{8'hFF, 8'h00, 8'h07, 8'h8C};
  localparam logic [7:0] PHASE_OFFS [PHASES-1] = '{8'hFF, 8'h00, 8'h80, 8'h01};
  localparam int PHASE_BYTES = 300;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [BYTE_W-1:0]   in_rx_byte = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          out_kind;
  logic [ADDR_W-1:0]   out_store_address;
  logic [BYTE_W-1:0]   out_store_data;

  crc_checked_frame_receiver_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_store_address (out_store_address),
    .out_store_data    (out_store_data)
  );

  // Shadow registers and frame parser state
  logic [7:0] cfg_poly = POLY_RESET;
  logic [7:0] cfg_offs = OFFS_RESET;
  bit         pred_in_frame = 1'b0;
  logic [7:0] pred_len = '0;
  logic [7:0] pred_pos = '0;
  logic [7:0] pred_check = '0;

  result_t pending_results [$];
  result_t front_result;
  bit      steady_run = 1'b0;
  int      mismatches = 0;
  int      bytes_sent = 0;
  int      results_seen = 0;
  int      frames_ok = 0;
  int      frames_failed = 0;
  int      long_frames = 0;
  int      phase_start;
  int      phase;
  logic [7:0] phase_poly;
  logic [7:0] phase_offs;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Reflected CRC-8 byte update: xor in, then eight conditional-xor/shift rounds
  function automatic logic [7:0] crc8_fold(logic [7:0] acc, logic [7:0] b, logic [7:0] poly);
    logic [7:0] v;
    v = acc ^ b;
    for (int r = 0; r < 8; r++) begin
      if (v[0]) v = v ^ poly;
      v = v >> 1;
    end
    return v;
  endfunction

  // Advance the frame parser by one byte; reports the result it causes, if any
  function automatic void frame_predict(input logic [7:0] b, output bit produced,
                                        output result_t res);
    res = '0;
    produced = 1'b0;
    if (!pred_in_frame) begin
      pred_len      = b;
      pred_pos      = '0;
      pred_check    = '0;
      pred_in_frame = 1'b1;
      return;
    end
    pred_check = crc8_fold(pred_check, b, cfg_poly);
    produced = 1'b1;
    if (pred_pos < pred_len) begin
      res.kind          = KIND_DATA;
      res.store_address = {1'b0, cfg_offs} + {1'b0, pred_pos};
      res.store_data    = b;
      pred_pos          = pred_pos + 8'd1;
    end else begin
      res.kind      = (pred_check == 8'd0) ? KIND_OK : KIND_FAIL;
      pred_in_frame = 1'b0;
    end
  endfunction

  task automatic report_mismatch(input string what, input int want_v, input int got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want_v, got_v);
  endtask

  // Send one item with random idle cycles ahead of it, then log its expectation
  task automatic push_byte(input logic [7:0] b, input bit typed, input result_t want);
    bit      produced;
    result_t pred;
    while (!steady_run && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    frame_predict(b, produced, pred);
    if (typed) pending_results.push_back(want);
    else if (produced) pending_results.push_back(pred);
  endtask

  // Length byte, data bytes, then a matching check byte most of the time
  task automatic send_frame(input bit force_long);
    int len;
    int pick;
    pick = $urandom_range(99);
    if (force_long || pick == 0) len = 255;
    else if (pick < 85) len = $urandom_range(12);
    else len = $urandom_range(255, 13);
    if (len == 255) long_frames++;
    push_byte(len[7:0], 1'b0, '0);
    repeat (len) push_byte(8'($urandom_range(255)), 1'b0, '0);
    if ($urandom_range(99) < 65) push_byte(pred_check, 1'b0, '0);
    else push_byte(8'($urandom_range(255)), 1'b0, '0);
  endtask

  // Let the block go quiet; a length byte may still be in its pipeline
  task automatic settle;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_POLY) cfg_poly = val;
    else cfg_offs = val;
    @(posedge clk);
  endtask

  // Receiver side stall
  always @(posedge clk) begin
    out_stall <= !steady_run && ($urandom_range(99) < 37);
  end

  // Score each accepted result against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result kind", -1, out_kind);
      end else begin
        front_result = pending_results.pop_front();
        if (front_result.kind !== out_kind)
          report_mismatch("kind", front_result.kind, out_kind);
        if (front_result.store_address !== out_store_address)
          report_mismatch("store_address", front_result.store_address, out_store_address);
        if (front_result.store_data !== out_store_data)
          report_mismatch("store_data", front_result.store_data, out_store_data);
        if (front_result.kind == KIND_OK) frames_ok++;
        if (front_result.kind == KIND_FAIL) frames_failed++;
      end
    end
  end

  // Main sequence
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames at reset settings
    for (int i = 0; i < DIR_ROWS_N; i++)
      push_byte(DIR_ROWS[i].good_check ? pred_check : DIR_ROWS[i].rx,
                DIR_ROWS[i].typed, DIR_ROWS[i].want);

    // Random phases, each under its own register setting
    for (phase = 0; phase < PHASES; phase++) begin
      settle();
      phase_poly = (phase < PHASES - 1) ? PHASE_POLY[phase] : 8'($urandom_range(255));
      phase_offs = (phase < PHASES - 1) ? PHASE_OFFS[phase] : 8'($urandom_range(255));
      cfg_write(REG_POLY, phase_poly);
      cfg_write(REG_OFFS, phase_offs);
      steady_run <= (phase == 2);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        // occasional stray bytes knock the framing out of step
        if (bytes_sent != phase_start && $urandom_range(99) < 8)
          repeat ($urandom_range(6, 1)) push_byte(8'($urandom_range(255)), 1'b0, '0);
        else
          send_frame(phase == 0 && bytes_sent == phase_start);
      end
    end

    settle();
    repeat (4) @(posedge clk);
    $display("Sent %0d bytes (%0d full-length frames) over %0d register settings.",
             bytes_sent, long_frames, PHASES + 1);
    $display("Checked %0d results: %0d frames passed, %0d failed; %0d mismatches.",
             results_seen, frames_ok, frames_failed, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("crc_checked_frame_receiver_top regression: pass");
    end else begin
      $display("crc_checked_frame_receiver_top regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Timed out with %0d results outstanding.", pending_results.size());
    $display("crc_checked_frame_receiver_top regression: fail");
    $finish;
  end

endmodule
